### hdl/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic take_value;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

### hdl/deq_cell.sv
module deq_cell (
  input  logic                                clk_i,
  input  deq_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   value_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   left_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   right_i,
  output logic signed [deq_pkg::WORD_W-1:0]   word_o
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.take_value) begin
      word_d = value_i;
    end else if (ctrl_i.take_left) begin
      word_d = left_i;
    end else if (ctrl_i.take_right) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

### hdl/double_ended_queue.sv
// Channel | Direction | Handshake                  | Fields
// in      | input     | in_valid_i / in_ready_o    | action_i, value_i
// out     | output    | out_valid_o / out_ready_i  | word_out_o, status_o, occupancy_o
//
// Each item's result is registered and appears in the cycle after acceptance.
// The words sit in a row of cells, cell zero holding the front; a front push or
// pop shifts the whole row by one place in that cycle, and a back push loads one cell.
// A new item is taken while the previous result is being taken, one item per cycle while results are taken.
// Reset clears the item count and the output valid flag; cell contents and the held result are left as they are.
// A stalled output holds its result and blocks further items until it is taken.
module double_ended_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          action_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [deq_pkg::WORD_W-1:0]   word_out_o,
  output logic [1:0]                          status_o,
  output logic [deq_pkg::CNT_W-1:0]           occupancy_o
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] cell_word [DEPTH];
  cell_ctrl_t               cell_ctrl [DEPTH];

  logic [CNT_W-1:0]         count_d, count_q;
  logic                     out_valid_d, out_valid_q;
  logic signed [WORD_W-1:0] word_d, word_q;
  status_e                  status_d, status_q;
  logic [CNT_W-1:0]         occ_q;

  logic             in_fire, full, empty;
  logic             push_front_ok, push_back_ok, pop_front_ok, pop_back_ok;
  logic [IDX_W-1:0] back_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign back_idx   = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    push_front_ok = 1'b0;
    push_back_ok  = 1'b0;
    pop_front_ok  = 1'b0;
    pop_back_ok   = 1'b0;
    word_d        = '0;
    status_d      = ST_OK;
    case (action_e'(action_i))
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          push_front_ok = in_fire && (action_e'(action_i) == ACT_PUSH_FRONT);
          push_back_ok  = in_fire && (action_e'(action_i) == ACT_PUSH_BACK);
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          word_d       = cell_word[0];
          pop_front_ok = in_fire && (action_e'(action_i) == ACT_POP_FRONT);
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          word_d      = cell_word[back_idx];
          pop_back_ok = in_fire && (action_e'(action_i) == ACT_POP_BACK);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (push_front_ok || push_back_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_front_ok || pop_back_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_word, right_word;

    if (i == 0) begin : g_first
      assign left_word = value_i;
    end else begin : g_inner_left
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_right
      assign right_word = cell_word[i+1];
    end

    assign cell_ctrl[i].take_value = push_back_ok && (count_q == CNT_W'(i));
    assign cell_ctrl[i].take_left  = push_front_ok;
    assign cell_ctrl[i].take_right = pop_front_ok;

    deq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .value_i (value_i),
      .left_i  (left_word),
      .right_i (right_word),
      .word_o  (cell_word[i])
    );
  end

  assign out_valid_d = in_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q   <= word_d;
      status_q <= status_d;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = word_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

### hdl/deq_checker.sv
module deq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [deq_pkg::WORD_W-1:0]   word_out_o,
  input logic [1:0]                          status_o,
  input logic [deq_pkg::CNT_W-1:0]           occupancy_o
);
  import deq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_out_o)
      && $stable(status_o) && $stable(occupancy_o))
    else $error("Stalled result changed.");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= CNT_W'(DEPTH))
    else $error("Occupancy beyond depth.");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> word_out_o == '0 && occupancy_o == '0)
    else $error("Underflow result inconsistent.");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> word_out_o == '0
      && occupancy_o == CNT_W'(DEPTH))
    else $error("Overflow result inconsistent.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_FULL)
    else $error("Undefined status code.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

### verif/double_ended_queue_tb.sv
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam int RANDOM_ITEMS = 1550;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [1:0]               status;
    logic [CNT_W-1:0]         occupancy;
  } deque_result_t;

  // Tracks the deque contents and holds the results still owed by the block.
  class deque_scoreboard;
    logic signed [WORD_W-1:0] words [DEPTH];
    logic [IDX_W-1:0]         head;
    logic [CNT_W-1:0]         count;
    deque_result_t            owed_q [$];
    int                       errors;

    function new();
      head   = '0;
      count  = '0;
      errors = 0;
    endfunction

    function void note_item(logic [2:0] act, logic signed [WORD_W-1:0] val);
      deque_result_t    r;
      logic [IDX_W-1:0] pos;
      r.word   = '0;
      r.status = ST_OK;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (count == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (act == ACT_PUSH_FRONT) begin
              head        = head - 1'b1;
              words[head] = val;
            end else begin
              pos        = head + IDX_W'(count);
              words[pos] = val;
            end
            count = count + 1'b1;
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) pos = head;
            else pos = head + IDX_W'(count - 1'b1);
            r.word = words[pos];
            if (act == ACT_POP_FRONT) begin
              head  = head + 1'b1;
              count = count - 1'b1;
            end else if (act == ACT_POP_BACK) begin
              count = count - 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = count;
      owed_q = {owed_q, r};
    endfunction

    function void check_result(logic signed [WORD_W-1:0] word, logic [1:0] status,
                               logic [CNT_W-1:0] occupancy);
      deque_result_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: result with no item outstanding: word %0d status %0d occupancy %0d",
                 $realtime, word, status, occupancy);
        errors++;
        return;
      end
      e = owed_q[0];
      owed_q.delete(0);
      if (word !== e.word) begin
        $display("%0t: word mismatch: expected %0d, actual %0d", $realtime, e.word, word);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $realtime, e.status, status);
        errors++;
      end
      if (occupancy !== e.occupancy) begin
        $display("%0t: occupancy mismatch: expected %0d, actual %0d", $realtime, e.occupancy,
                 occupancy);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               action_i    = '0;
  logic signed [WORD_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [WORD_W-1:0] word_out_o;
  logic [1:0]               status_o;
  logic [CNT_W-1:0]         occupancy_o;

  bit              calm = 1'b0;
  deque_scoreboard sb   = new();

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_out_o  (word_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_item(input logic [2:0] act, input logic signed [WORD_W-1:0] val);
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, val);
  endtask

  function automatic logic [2:0] pick_action(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 1) return $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    if (r < push_pct) return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    case ($urandom_range(3))
      0:       return ACT_POP_FRONT;
      1:       return ACT_POP_BACK;
      2:       return ACT_PEEK_FRONT;
      default: return ACT_PEEK_BACK;
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int push_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_PEEK_FRONT, 32'sd5);
    send_item(ACT_PEEK_BACK, 32'sd6);
    send_item(ACT_POP_FRONT, 32'sd7);
    send_item(ACT_POP_BACK, 32'sd8);
    send_item(ACT_PUSH_FRONT, WORD_MAX);
    send_item(ACT_PUSH_BACK, WORD_MIN);
    send_item(ACT_PUSH_BACK, '0);
    send_item(ACT_PUSH_FRONT, -1);
    send_item(ACT_PEEK_FRONT, '0);
    send_item(ACT_PEEK_BACK, '0);
    send_item(ACT_SPARE_LO, 32'sd99);
    send_item(ACT_SPARE_HI, WORD_MAX);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_PEEK_FRONT, '0);

    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      calm = (n >= 700 && n < 1000);
      if (!calm && $urandom_range(99) < 10) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
      send_item(pick_action(push_pct), pick_value());
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

  initial begin : result_side
    int cyc;
    int hold;
    cyc  = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(word_out_o, status_o, occupancy_o);
      cyc++;
      // A long hold-off early in the run lets the block back up and stall its input.
      if (cyc == 400) hold = 80;
      else if (hold == 0 && !calm && $urandom_range(399) == 0) hold = $urandom_range(60, 20);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("double_ended_queue test failed");
    $finish;
  end

endmodule

### filelist.f
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue.sv
hdl/deq_checker.sv
verif/double_ended_queue_tb.sv
